[rtl/aps_pkg.sv]
// ----------------------------------------------------------------------------
// aps_pkg
// shared types, constants and a saturating add helper for the alignment pair
// statistics block
// ----------------------------------------------------------------------------
`default_nettype none

package aps_pkg;

  localparam int unsigned BaseW    = 8;
  localparam int unsigned CountW   = 16;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 48;

  localparam logic [BaseW-1:0] GapChar = 8'd45;

  localparam longint unsigned MaxLength = 64'd65535;
  localparam logic [CountW:0] CountLimit =
    (MaxLength > 64'd65535) ? 17'd65535 : 17'(MaxLength);

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = 2;

  typedef enum logic [2:0] {
    COL_SKIP,
    COL_MATCH,
    COL_MISMATCH,
    COL_ONLY_A,
    COL_ONLY_B,
    COL_BOTH_GAP
  } col_kind_t;

  typedef struct packed {
    col_kind_t kind;
    logic      last;
  } aps_cmd_t;

  typedef logic [CountW-1:0] count_t;

  function automatic count_t sat_add(input count_t a, input count_t b);
    logic [CountW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > CountLimit) ? CountLimit[CountW-1:0] : s[CountW-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/alignment_pair_statistics_top.sv]
// ----------------------------------------------------------------------------
// alignment_pair_statistics_top
// match, mismatch and indel counts over the internal columns of a pairwise
// alignment
// ----------------------------------------------------------------------------
// One alignment column is taken per cycle while the command queue has room.
// The column marked tlast passes through the four-entry command queue, behind
// any earlier commands still waiting there, and its result is then registered
// in the output register; columns keep flowing while a result waits in the
// output register, and the input stalls only when that queue fills behind an
// untaken result. Counts saturate at 65535, and all state clears after each
// result so the next alignment starts immediately.
`default_nettype none

module alignment_pair_statistics_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [aps_pkg::InDataW-1:0]  in_tdata,   // base_a, base_b
  input  wire logic                         in_tlast,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [aps_pkg::OutDataW-1:0]      out_tdata   // match, mismatch, indel
);
  import aps_pkg::*;

  logic     q_push, q_full, q_pop, q_not_empty;
  aps_cmd_t push_cmd, head_cmd;

  aps_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  aps_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_cmd  (head_cmd)
  );

  aps_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_cmd       (head_cmd),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule

`default_nettype wire

[rtl/aps_front.sv]
// ----------------------------------------------------------------------------
// aps_front
// accepts alignment columns, tracks which rows have started and classifies
// each column into a counter command
// ----------------------------------------------------------------------------
`default_nettype none

module aps_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  input  wire logic [aps_pkg::InDataW-1:0] in_tdata,  // base_a, base_b
  input  wire logic                       in_tlast,
  input  wire logic                       q_full,
  output logic                            q_push,
  output aps_pkg::aps_cmd_t               q_cmd
);
  import aps_pkg::*;

  logic             seen_a_r, seen_a_nxt;
  logic             seen_b_r, seen_b_nxt;
  logic [BaseW-1:0] base_a, base_b;
  logic             a_base, b_base;

  assign base_a    = in_tdata[BaseW-1:0];
  assign base_b    = in_tdata[2*BaseW-1:BaseW];
  assign a_base    = (base_a != GapChar);
  assign b_base    = (base_b != GapChar);
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && in_tready;

  always_comb begin
    seen_a_nxt = seen_a_r || a_base;
    seen_b_nxt = seen_b_r || b_base;
    q_cmd.last = in_tlast;
    if (!(seen_a_nxt && seen_b_nxt)) begin
      q_cmd.kind = COL_SKIP;
    end else if (a_base && b_base) begin
      q_cmd.kind = (base_a == base_b) ? COL_MATCH : COL_MISMATCH;
    end else if (a_base) begin
      q_cmd.kind = COL_ONLY_A;
    end else if (b_base) begin
      q_cmd.kind = COL_ONLY_B;
    end else begin
      q_cmd.kind = COL_BOTH_GAP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_a_r <= 1'b0;
      seen_b_r <= 1'b0;
    end else if (q_push) begin
      seen_a_r <= in_tlast ? 1'b0 : seen_a_nxt;
      seen_b_r <= in_tlast ? 1'b0 : seen_b_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/aps_queue.sv]
// ----------------------------------------------------------------------------
// aps_queue
// small register queue of column commands between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module aps_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire aps_pkg::aps_cmd_t push_cmd,
  output logic                   full,
  input  wire logic              pop,
  output logic                   not_empty,
  output aps_pkg::aps_cmd_t      head_cmd
);
  import aps_pkg::*;

  aps_cmd_t       mem_r [QDepth];
  logic [QAw-1:0] wr_ptr_r, rd_ptr_r;
  logic [QAw:0]   cnt_r;

  assign full      = (cnt_r == (QAw+1)'(QDepth));
  assign not_empty = (cnt_r != '0);
  assign head_cmd  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

[rtl/aps_back.sv]
// ----------------------------------------------------------------------------
// aps_back
// applies column commands to the saturating counters and registers the
// result of each alignment
// ----------------------------------------------------------------------------
`default_nettype none

module aps_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        q_not_empty,
  input  wire aps_pkg::aps_cmd_t           q_cmd,
  output logic                             q_pop,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [aps_pkg::OutDataW-1:0]     out_tdata  // match, mismatch, indel
);
  import aps_pkg::*;

  logic   first_leads_r, first_leads_nxt;
  count_t matches_r, matches_nxt;
  count_t mismatches_r, mismatches_nxt;
  count_t done_r, done_nxt;
  count_t between_r, between_nxt;
  count_t after_r, after_nxt;
  logic   out_valid_r;
  logic [OutDataW-1:0] out_data_r;
  logic   row_first;

  assign q_pop      = q_not_empty && (!q_cmd.last || !out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    first_leads_nxt = first_leads_r;
    matches_nxt     = matches_r;
    mismatches_nxt  = mismatches_r;
    done_nxt        = done_r;
    between_nxt     = between_r;
    after_nxt       = after_r;
    row_first       = (q_cmd.kind == COL_ONLY_A);
    case (q_cmd.kind)
      COL_MATCH, COL_MISMATCH: begin
        done_nxt    = sat_add(sat_add(done_r, between_r), after_r);
        between_nxt = '0;
        after_nxt   = '0;
        if (q_cmd.kind == COL_MATCH) begin
          matches_nxt = sat_add(matches_r, count_t'(1));
        end else begin
          mismatches_nxt = sat_add(mismatches_r, count_t'(1));
        end
      end
      COL_ONLY_A, COL_ONLY_B: begin
        if (first_leads_r != row_first) begin
          done_nxt    = sat_add(done_r, between_r);
          between_nxt = sat_add(after_r, count_t'(1));
        end else begin
          between_nxt = sat_add(sat_add(between_r, after_r), count_t'(1));
        end
        after_nxt       = '0;
        first_leads_nxt = row_first;
      end
      COL_BOTH_GAP: begin
        after_nxt = sat_add(after_r, count_t'(1));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_leads_r <= 1'b0;
      matches_r     <= '0;
      mismatches_r  <= '0;
      done_r        <= '0;
      between_r     <= '0;
      after_r       <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (q_pop && q_cmd.last) begin
        out_valid_r   <= 1'b1;
        out_data_r    <= {done_nxt, mismatches_nxt, matches_nxt};
        first_leads_r <= 1'b0;
        matches_r     <= '0;
        mismatches_r  <= '0;
        done_r        <= '0;
        between_r     <= '0;
        after_r       <= '0;
      end else begin
        if (out_tready) begin
          out_valid_r <= 1'b0;
        end
        if (q_pop) begin
          first_leads_r <= first_leads_nxt;
          matches_r     <= matches_nxt;
          mismatches_r  <= mismatches_nxt;
          done_r        <= done_nxt;
          between_r     <= between_nxt;
          after_r       <= after_nxt;
        end
      end
    end
  end

endmodule

`default_nettype wire

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Checks the alignment pair statistics block against a cycle-free model of
// its column counting. A queue of columns feeds a stream driver. Every
// accepted column updates the model, and each final column adds one
// expected set of counts. A monitor compares every result with the oldest
// expected set. The stimulus has directed alignments and random alignments
// with overhangs and gaps. The idle pattern of both sides changes from phase
// to phase.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import aps_pkg::*;

  typedef struct {
    logic [BaseW-1:0] base_a;
    logic [BaseW-1:0] base_b;
    logic             last;
  } column_t;

  typedef struct {
    count_t match;
    count_t mismatch;
    count_t indel;
  } counts_t;

  localparam logic [CountW:0] SatLimit =
    (MaxLength > 64'd65535) ? 17'd65535 : 17'(MaxLength);

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata = '0;
  logic                in_tlast = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;

  column_t pending_cols[$];
  counts_t expected_counts[$];
  column_t cur_col;
  int      queued_cols = 0;
  int      error_count = 0;
  int      send_idle_pct = 21;
  int      recv_idle_pct = 82;

  // column model state
  logic   seen_a = 1'b0;
  logic   seen_b = 1'b0;
  logic   a_leads = 1'b0;
  count_t matched = '0;
  count_t mismatched = '0;
  count_t indels_firm = '0;
  count_t indels_pending = '0;
  count_t indels_tail = '0;

  alignment_pair_statistics_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic count_t add_sat(input count_t x, input count_t y);
    logic [CountW:0] s;
    s = {1'b0, x} + {1'b0, y};
    return (s > SatLimit) ? SatLimit[CountW-1:0] : s[CountW-1:0];
  endfunction

  // a non-gap in one row only
  task automatic gap_in_other_row(input logic row_a);
    if (a_leads != row_a) begin
      indels_firm = add_sat(indels_firm, indels_pending);
      indels_pending = '0;
    end
    indels_pending = add_sat(add_sat(indels_pending, indels_tail), 16'd1);
    indels_tail = '0;
    a_leads = row_a;
  endtask

  task automatic tally_column(input column_t col);
    logic    a_base;
    logic    b_base;
    counts_t res;
    a_base = (col.base_a != GapChar);
    b_base = (col.base_b != GapChar);
    seen_a = seen_a | a_base;
    seen_b = seen_b | b_base;
    if (seen_a && seen_b) begin
      if (a_base && b_base) begin
        indels_firm = add_sat(indels_firm, indels_pending);
        indels_firm = add_sat(indels_firm, indels_tail);
        indels_pending = '0;
        indels_tail = '0;
        if (col.base_a == col.base_b) matched = add_sat(matched, 16'd1);
        else mismatched = add_sat(mismatched, 16'd1);
      end else if (a_base) begin
        gap_in_other_row(1'b1);
      end else if (b_base) begin
        gap_in_other_row(1'b0);
      end else begin
        indels_tail = add_sat(indels_tail, 16'd1);
      end
    end
    if (col.last) begin
      res.match = matched;
      res.mismatch = mismatched;
      res.indel = indels_firm;
      expected_counts.insert(expected_counts.size(), res);
      seen_a = 1'b0;
      seen_b = 1'b0;
      a_leads = 1'b0;
      matched = '0;
      mismatched = '0;
      indels_firm = '0;
      indels_pending = '0;
      indels_tail = '0;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) tally_column(cur_col);
      if (!in_tvalid || in_tready) begin
        if (pending_cols.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_col = pending_cols.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= {cur_col.base_b, cur_col.base_a};
          in_tlast <= cur_col.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  function automatic int check_field(input string name, input count_t exp_v,
                                     input count_t act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  // monitor
  always @(posedge clk) begin
    counts_t exp_c;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_counts.size() == 0) begin
          $error("result with no request pending: %h", out_tdata);
          error_count++;
        end else begin
          exp_c = expected_counts.pop_front();
          error_count += check_field("match_count", exp_c.match, out_tdata[15:0]);
          error_count += check_field("mismatch_count", exp_c.mismatch, out_tdata[31:16]);
          error_count += check_field("indel_count", exp_c.indel, out_tdata[47:32]);
        end
      end
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic push_col(input logic [7:0] a, input logic [7:0] b, input logic last);
    column_t col;
    col.base_a = a;
    col.base_b = b;
    col.last = last;
    pending_cols.insert(pending_cols.size(), col);
    queued_cols++;
  endtask

  task automatic push_alignment(input string row_a, input string row_b);
    for (int i = 0; i < row_a.len(); i++)
      push_col(row_a[i], row_b[i], i == row_a.len() - 1);
  endtask

  function automatic logic [7:0] pick_base(input bit noisy, input int gap_pct);
    string letters;
    letters = "ACGT";
    if ($urandom_range(0, 99) < gap_pct) return GapChar;
    if (noisy) return 8'($urandom_range(0, 255));
    return letters[$urandom_range(0, 3)];
  endfunction

  task automatic push_random_alignment();
    int          len;
    int          gap_a;
    int          gap_b;
    int          lead;
    int          trail;
    bit          noisy;
    bit          lead_in_a;
    bit          trail_in_a;
    logic [7:0]  a;
    logic [7:0]  b;
    len = $urandom_range(1, 14);
    gap_a = $urandom_range(0, 50);
    gap_b = $urandom_range(0, 50);
    lead = $urandom_range(0, 3);
    trail = $urandom_range(0, 3);
    noisy = ($urandom_range(0, 7) == 0);
    lead_in_a = 1'($urandom_range(0, 1));
    trail_in_a = 1'($urandom_range(0, 1));
    for (int i = 0; i < len; i++) begin
      a = pick_base(noisy, gap_a);
      b = pick_base(noisy, gap_b);
      if (a != GapChar && b != GapChar && $urandom_range(0, 99) < 55) b = a;
      if (i < lead) begin
        if (lead_in_a) a = GapChar;
        else b = GapChar;
      end
      if (i >= len - trail) begin
        if (trail_in_a) a = GapChar;
        else b = GapChar;
      end
      push_col(a, b, i == len - 1);
    end
  endtask

  task automatic wait_drained();
    while (pending_cols.size() > 0 || in_tvalid || expected_counts.size() > 0)
      @(negedge clk);
  endtask

  task automatic push_random_phase(input int n);
    int target;
    target = queued_cols + n;
    while (queued_cols < target) push_random_alignment();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed alignments
    push_alignment("A", "A");
    push_alignment("-", "-");
    push_col(8'h00, 8'hFF, 1'b0);
    push_col(8'hFF, 8'hFF, 1'b0);
    push_col(8'hFF, 8'h00, 1'b1);
    push_alignment("--AC-GT--", "-TA-GG-C-");
    push_alignment("----", "ABCD");
    push_alignment("AT-G-", "A-CGA");
    push_random_phase(250);
    wait_drained();

    send_idle_pct = 82;
    recv_idle_pct = 21;
    push_random_phase(270);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    push_random_phase(270);
    wait_drained();

    repeat (10) @(negedge clk);
    if (expected_counts.size() > 0) begin
      $error("%0d expected results never arrived", expected_counts.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
rtl/aps_pkg.sv
rtl/aps_front.sv
rtl/aps_queue.sv
rtl/aps_back.sv
rtl/alignment_pair_statistics_top.sv
verif/testbench.sv
